@@ rtl/rwt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwt_pkg
// Shared sizes, request kinds, adder opcodes and sequencer states for the
// range window translator.
// ----------------------------------------------------------------------------
package rwt_pkg;

  localparam int WINDOWS   = 16;
  localparam int ADDR_BITS = 48;

  localparam int FIELD_W = 48;
  localparam int CFG_W   = 5;
  localparam int SLOT_W  = 4;

  localparam int IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int CNT_W = $clog2(WINDOWS + 1);
  localparam int UW    = (ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_RANGE = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic          carry;
    logic [UW-1:0] val;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_GAP,
    ST_MOFF,
    ST_MLEN,
    ST_CLIP,
    ST_START,
    ST_EMIT,
    ST_ACUR,
    ST_AREM,
    ST_TAIL
  } state_e;

endpackage
`default_nettype wire

@@ rtl/range_window_translator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A load request is accepted while the sequencer is idle and writes its slot at once.
// A range request walks the windows in slot order on one shared adder and
// emits gap and mapped pieces per window, then any trailing piece, and waits
// while the output register is stalled. One request in flight at a time.
// Reset clears window_count and the sequencer; the window table is not cleared.
// ----------------------------------------------------------------------------
// range_window_translator
// Splits an address range along a table of translation windows and emits
// one translated or passed-through piece per output request.
// ----------------------------------------------------------------------------
module range_window_translator import rwt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic [SLOT_W-1:0]  entry_slot_i,
  input  wire logic [FIELD_W-1:0] dest_base_i,
  input  wire logic [FIELD_W-1:0] src_base_i,
  input  wire logic [FIELD_W-1:0] window_len_i,
  input  wire logic [FIELD_W-1:0] range_start_i,
  input  wire logic [FIELD_W-1:0] range_size_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [FIELD_W-1:0]      piece_start_o,
  output logic [FIELD_W-1:0]      piece_size_o,
  output logic                    piece_mapped_o,
  output logic                    last_piece_o
);

  // window table
  logic [ADDR_BITS-1:0] win_dest [WINDOWS];
  logic [ADDR_BITS-1:0] win_src  [WINDOWS];
  logic [ADDR_BITS-1:0] win_len  [WINDOWS];

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     window_count_q;
  logic [CNT_W-1:0]     i_q, i_d;
  logic [ADDR_BITS-1:0] cur_q, cur_d;
  logic [FIELD_W-1:0]   rem_q, rem_d;
  logic [ADDR_BITS-1:0] s_q, len_q, dest_q;
  logic [ADDR_BITS-1:0] off_q, off_d;
  logic [UW-1:0]        t_q, t_d;
  logic [ADDR_BITS-1:0] ps_q, ps_d;
  logic                 mapped_q, mapped_d;
  logic                 last_q, last_d;

  logic                 out_valid_q, out_valid_d;
  logic [FIELD_W-1:0]   piece_start_q, piece_size_q;
  logic                 piece_mapped_q, last_piece_q;
  logic                 out_load;

  logic                 in_accept;
  logic                 load_req;
  logic [IDX_W-1:0]     slot_idx;
  logic [CNT_W-1:0]     eff_cnt;
  logic [CNT_W-1:0]     i_next;
  logic                 last_win;

  alu_op_e              alu_op;
  logic [UW-1:0]        alu_a, alu_b;
  alu_res_t             alu_res;

  rwt_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign load_req   = in_accept && (kind_i == KIND_LOAD);
  assign slot_idx   = IDX_W'(entry_slot_i);

  always_comb begin
    if (32'(window_count_q) > 32'(WINDOWS)) begin
      eff_cnt = CNT_W'(WINDOWS);
    end else begin
      eff_cnt = CNT_W'(window_count_q);
    end
  end

  assign i_next   = i_q + CNT_W'(1);
  assign last_win = (i_next >= eff_cnt);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_count_q <= '0;
    end else if (cfg_we_i) begin
      window_count_q <= cfg_wdata_i;
    end
  end

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (load_req && (32'(entry_slot_i) < 32'(WINDOWS))) begin
      win_dest[slot_idx] <= ADDR_BITS'(dest_base_i);
      win_src[slot_idx]  <= ADDR_BITS'(src_base_i);
      win_len[slot_idx]  <= ADDR_BITS'(window_len_i);
    end
    if (state_q == ST_FETCH) begin
      s_q    <= win_src[i_q[IDX_W-1:0]];
      len_q  <= win_len[i_q[IDX_W-1:0]];
      dest_q <= win_dest[i_q[IDX_W-1:0]];
    end
  end

  // adder operand select
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    case (state_q)
      ST_GAP: begin
        alu_a = UW'(s_q);
        alu_b = UW'(cur_q);
      end
      ST_MOFF: begin
        alu_a = UW'(cur_q);
        alu_b = UW'(s_q);
      end
      ST_MLEN: begin
        alu_a = UW'(len_q);
        alu_b = UW'(off_q);
      end
      ST_CLIP, ST_AREM: begin
        alu_a = UW'(rem_q);
        alu_b = t_q;
      end
      ST_START: begin
        alu_op = ALU_ADD;
        alu_a  = UW'(dest_q);
        alu_b  = UW'(off_q);
      end
      ST_ACUR: begin
        alu_op = ALU_ADD;
        alu_a  = UW'(cur_q);
        alu_b  = t_q;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    cur_d    = cur_q;
    rem_d    = rem_q;
    off_d    = off_q;
    t_d      = t_q;
    ps_d     = ps_q;
    mapped_d = mapped_q;
    last_d   = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (kind_i == KIND_RANGE)) begin
          cur_d = ADDR_BITS'(range_start_i);
          rem_d = range_size_i;
          i_d   = '0;
          if (range_size_i == '0) begin
            state_d = ST_IDLE;
          end else if (eff_cnt == '0) begin
            state_d = ST_TAIL;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_GAP;
      end
      ST_GAP: begin
        // gap below the window when src - cur is positive
        if (!alu_res.carry && (alu_res.val != '0)) begin
          t_d      = alu_res.val;
          mapped_d = 1'b0;
          state_d  = ST_CLIP;
        end else begin
          state_d = ST_MOFF;
        end
      end
      ST_MOFF: begin
        if (alu_res.carry) begin
          i_d     = i_next;
          state_d = last_win ? ST_TAIL : ST_FETCH;
        end else begin
          off_d   = ADDR_BITS'(alu_res.val);
          state_d = ST_MLEN;
        end
      end
      ST_MLEN: begin
        // exclusive end: offset must be strictly below the length
        if (alu_res.carry || (alu_res.val == '0)) begin
          i_d     = i_next;
          state_d = last_win ? ST_TAIL : ST_FETCH;
        end else begin
          t_d      = alu_res.val;
          mapped_d = 1'b1;
          state_d  = ST_CLIP;
        end
      end
      ST_CLIP: begin
        if (alu_res.carry) begin
          t_d = UW'(rem_q);
        end
        last_d  = alu_res.carry || (alu_res.val == '0);
        state_d = ST_START;
      end
      ST_START: begin
        ps_d    = mapped_q ? ADDR_BITS'(alu_res.val) : cur_q;
        state_d = ST_EMIT;
      end
      ST_TAIL: begin
        ps_d     = cur_q;
        t_d      = UW'(rem_q);
        mapped_d = 1'b0;
        last_d   = 1'b1;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = last_q ? ST_IDLE : ST_ACUR;
        end
      end
      ST_ACUR: begin
        cur_d   = ADDR_BITS'(alu_res.val);
        state_d = ST_AREM;
      end
      ST_AREM: begin
        rem_d = FIELD_W'(alu_res.val);
        // after a mapped piece move to the next window, after a gap try mapping
        if (mapped_q) begin
          i_d     = i_next;
          state_d = last_win ? ST_TAIL : ST_FETCH;
        end else begin
          state_d = ST_MOFF;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    rem_q    <= rem_d;
    off_q    <= off_d;
    t_q      <= t_d;
    ps_q     <= ps_d;
    mapped_q <= mapped_d;
    last_q   <= last_d;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      piece_start_q  <= FIELD_W'(ps_q);
      piece_size_q   <= FIELD_W'(t_q);
      piece_mapped_q <= mapped_q;
      last_piece_q   <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign piece_start_o  = piece_start_q;
  assign piece_size_o   = piece_size_q;
  assign piece_mapped_o = piece_mapped_q;
  assign last_piece_o   = last_piece_q;

endmodule
`default_nettype wire

@@ rtl/rwt_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwt_alu
// Shared add/subtract unit; carry out doubles as the borrow on subtract.
// ----------------------------------------------------------------------------
module rwt_alu import rwt_pkg::*; (
  input  alu_op_e       op_i,
  input  logic [UW-1:0] a_i,
  input  logic [UW-1:0] b_i,
  output alu_res_t      res_o
);

  logic [UW:0] sum;

  always_comb begin
    case (op_i)
      ALU_ADD: sum = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: sum = {1'b0, a_i} - {1'b0, b_i};
      default: sum = '0;
    endcase
  end

  assign res_o.carry = sum[UW];
  assign res_o.val   = sum[UW-1:0];

endmodule
`default_nettype wire
